### design/decision_tree_inference_macros.svh
// Assertion macros for the decision tree inference block.
// Included by the top level; no other dependencies.
`ifndef DECISION_TREE_INFERENCE_MACROS_SVH
`define DECISION_TREE_INFERENCE_MACROS_SVH

`ifndef SYNTHESIS
`define DTI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DTI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DTI_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DTI_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### design/dti_pkg.sv
// Shared types for the decision tree inference block: item function codes
// and the command/status structs between controller and datapath.
package dti_pkg;

  typedef enum logic [1:0] {
    FUNC_WR_NODE = 2'd0,
    FUNC_WR_FEAT = 2'd1,
    FUNC_PREDICT = 2'd2
  } func_t;

  typedef struct packed {
    logic load_root;
    logic step;
    logic wr_node;
    logic wr_feat;
    logic load_out;
  } dti_cmd_t;

  typedef struct packed {
    logic terminal;
    logic out_busy;
  } dti_status_t;

endpackage

### design/dti_datapath.sv
// Datapath: node memory, feature registers, walk registers and output register.
// Depends on dti_pkg.
module dti_datapath import dti_pkg::*; #(
  parameter int TREE_DEPTH = 6,
  parameter int FEATURES   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dti_cmd_t           cmd,
  output dti_status_t        status,
  input  logic [6:0]         node_index,
  input  logic               node_is_leaf,
  input  logic [3:0]         node_feature,
  input  logic signed [31:0] node_value,
  input  logic [3:0]         feature_index,
  input  logic signed [31:0] feature_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] prediction,
  output logic [6:0]         leaf_index,
  output logic               walk_error
);

  localparam int NODES     = (1 << (TREE_DEPTH + 1)) - 1;
  localparam int NODE_W    = TREE_DEPTH + 1;
  localparam int MEM_AW    = (NODE_W < 7) ? NODE_W : 7;
  localparam int MEM_DEPTH = 1 << MEM_AW;
  localparam int DEPTH_W   = $clog2(TREE_DEPTH + 1);
  localparam int FS_DEPTH  = (FEATURES < 16) ? FEATURES : 16;

  // node memory entry: {leaf, feature, value}
  logic [36:0]        node_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] node_valid;
  logic [36:0]        mem_q;
  logic               q_valid;
  logic               q_inmem;

  logic signed [31:0] feat [16];

  logic [NODE_W-1:0]  node;
  logic [DEPTH_W-1:0] depth;

  logic               node_ok;
  logic               feat_ok;
  logic               entry_ok;
  logic               leaf_eff;
  logic [3:0]         feat_sel;
  logic signed [31:0] value_eff;
  logic signed [31:0] x;
  logic               go_right;
  logic [NODE_W-1:0]  child;
  logic [MEM_AW-1:0]  rd_addr;
  logic               rd_inmem;
  logic               at_bottom;
  logic [13:0]        node_ext;

  assign node_ok = {7'd0, node_index} < 14'(NODES);
  assign feat_ok = {1'b0, feature_index} < 5'(FS_DEPTH);

  assign entry_ok  = q_valid && q_inmem;
  assign leaf_eff  = !entry_ok || mem_q[36];
  assign feat_sel  = entry_ok ? mem_q[35:32] : 4'd0;
  assign value_eff = entry_ok ? $signed(mem_q[31:0]) : 32'sd0;
  assign x         = ({1'b0, feat_sel} < 5'(FS_DEPTH)) ? feat[feat_sel] : 32'sd0;
  assign go_right  = !(x < value_eff);
  assign child     = (node << 1) + (go_right ? NODE_W'(2) : NODE_W'(1));
  assign at_bottom = depth == DEPTH_W'(TREE_DEPTH);

  assign rd_addr  = cmd.load_root ? '0 : child[MEM_AW-1:0];
  assign rd_inmem = cmd.load_root ? 1'b1 : ((child >> MEM_AW) == '0);

  assign status.terminal = leaf_eff || at_bottom;
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.wr_node && node_ok) begin
      node_mem[node_index[MEM_AW-1:0]] <= {node_is_leaf, node_feature, node_value};
    end
    if (cmd.load_root || cmd.step) begin
      mem_q   <= node_mem[rd_addr];
      q_inmem <= rd_inmem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_valid <= '0;
      q_valid    <= 1'b0;
    end else begin
      if (cmd.wr_node && node_ok) begin
        node_valid[node_index[MEM_AW-1:0]] <= 1'b1;
      end
      if (cmd.load_root || cmd.step) begin
        q_valid <= node_valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        feat[i] <= 32'sd0;
      end
    end else if (cmd.wr_feat && feat_ok) begin
      feat[feature_index] <= feature_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_root) begin
      node  <= '0;
      depth <= '0;
    end else if (cmd.step) begin
      node  <= child;
      depth <= depth + DEPTH_W'(1);
    end
  end

  assign node_ext = 14'(node);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      prediction <= value_eff;
      leaf_index <= node_ext[6:0];
      walk_error <= !leaf_eff;
    end
  end

endmodule

### design/dti_controller.sv
// Controller: decodes input items and sequences the tree walk.
// Depends on dti_pkg.
module dti_controller import dti_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  func_t       func,
  output logic        in_ready,
  input  dti_status_t status,
  output dti_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = state == ST_IDLE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_WR_NODE: cmd.wr_node = 1'b1;
            FUNC_WR_FEAT: cmd.wr_feat = 1'b1;
            FUNC_PREDICT: begin
              cmd.load_root = 1'b1;
              state_next    = ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (!status.terminal) begin
          cmd.step = 1'b1;
        end else if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### design/decision_tree_inference.sv
// Decision tree inference, top level. Instantiates dti_controller and
// dti_datapath; uses dti_pkg and decision_tree_inference_macros.svh.
//
// Input channel s_*: each item is a write-node, write-feature or predict
// command, selected by s_tuser. Writes take effect in the accept cycle and
// give no result. A predict walks the heap-ordered tree from the root, one
// level per cycle: the node memory's registered read feeds the feature
// select and signed compare, which forms the child address for the next
// read. The walk ends at a leaf or at depth TREE_DEPTH. No new item is
// accepted until the walk's result is loaded into the output register;
// writes leave the controller idle, so the input stays ready after them.
// Output channel m_*: one item per predict, held in an output register, so
// a new item may be accepted while a result waits. If the receiver stalls
// and a second walk completes, that walk holds until the register frees.
// Reset marks every node a leaf with value zero (per-node valid bits) and
// clears the feature vector and the output valid flag.
`include "decision_tree_inference_macros.svh"

module decision_tree_inference import dti_pkg::*; #(
  parameter int TREE_DEPTH = 6,
  parameter int FEATURES   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // node_index[6:0], node_is_leaf[7], node_feature[11:8], node_value[43:12],
  // feature_index[47:44], feature_value[79:48]
  input  logic [79:0] s_tdata,
  // func[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // prediction[31:0], leaf_index[38:32], zero[39]
  output logic [39:0] m_tdata,
  // walk_error[0]
  output logic [0:0]  m_tuser
);

  dti_cmd_t    cmd;
  dti_status_t status;

  logic signed [31:0] prediction;
  logic [6:0]         leaf_index;
  logic               walk_error;

  dti_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .func     (func_t'(s_tuser)),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dti_datapath #(
    .TREE_DEPTH (TREE_DEPTH),
    .FEATURES   (FEATURES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .node_index    (s_tdata[6:0]),
    .node_is_leaf  (s_tdata[7]),
    .node_feature  (s_tdata[11:8]),
    .node_value    (s_tdata[43:12]),
    .feature_index (s_tdata[47:44]),
    .feature_value (s_tdata[79:48]),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .prediction    (prediction),
    .leaf_index    (leaf_index),
    .walk_error    (walk_error)
  );

  assign m_tdata = {1'b0, leaf_index, prediction};
  assign m_tuser = walk_error;

  `DTI_ASSERT_IMP(a_load_at_end, clk, rst, cmd.load_out, status.terminal)
  `DTI_ASSERT_IMP(a_step_busy, clk, rst, cmd.step, !s_tready && !status.terminal)
  `DTI_ASSERT_IMP(a_write_on_accept, clk, rst, cmd.wr_node || cmd.wr_feat,
                  s_tvalid && s_tready)
  `DTI_ASSERT_NXT(a_walk_blocks_input, clk, rst, cmd.load_root, !s_tready)

endmodule
